// ===== rtl/core/srb_pkg.sv =====
// Shared types and constants for the sequenced packet reorder buffer.
package srb_pkg;

    localparam int SEQ_BITS             = 31;
    localparam int WINDOW_SLOTS_DEFAULT = 16;
    localparam int EXTRA_DEPTH_DEFAULT  = 4;
    localparam int HANDLE_BITS_DEFAULT  = 32;

    typedef enum logic [1:0] {
        CMD_REG_RELIABLE = 2'd0,
        CMD_REG_BEST     = 2'd1,
        CMD_FETCH        = 2'd2
    } cmd_t;

    // Outcome of one command, plus the descriptor store accesses it needs.
    typedef struct packed {
        logic accepted;
        logic delivered;
        logic kind;
        logic rel_wr;
        logic rel_rd;
        logic ext_wr;
        logic ext_rd;
    } srb_flags_t;

endpackage

// ===== rtl/core/srb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module srb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/srb_slot_ctrl.sv =====
// Per-slot state, window check and command decision for the reorder buffer.
module srb_slot_ctrl import srb_pkg::*; #(
    parameter int WINDOW_SLOTS = WINDOW_SLOTS_DEFAULT,
    parameter int EXTRA_DEPTH  = EXTRA_DEPTH_DEFAULT,
    localparam int SW  = $clog2(WINDOW_SLOTS),
    localparam int EAW = $clog2(WINDOW_SLOTS * EXTRA_DEPTH)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic [1:0]          cmd,
    input  logic [SEQ_BITS-1:0] packet_sequence,
    output srb_flags_t          flags,
    output logic [SEQ_BITS-1:0] cur_sequence,
    output logic [SW-1:0]       rel_addr,
    output logic [EAW-1:0]      ext_addr
);

    localparam int CW = $clog2(EXTRA_DEPTH + 1);
    localparam int HW = (EXTRA_DEPTH > 1) ? $clog2(EXTRA_DEPTH) : 1;
    localparam int PW = CW + 1;
    localparam logic [SEQ_BITS-1:0] WIN_S    = SEQ_BITS'(WINDOW_SLOTS);
    localparam logic [SEQ_BITS-1:0] SEQ_MAX  = {SEQ_BITS{1'b1}};
    localparam logic [SW:0]         WIN_W    = (SW + 1)'(WINDOW_SLOTS);
    localparam logic [SW-1:0]       SLOT_MAX = SW'(WINDOW_SLOTS - 1);
    localparam logic [CW-1:0]       CNT_FULL = CW'(EXTRA_DEPTH);
    localparam logic [PW-1:0]       DEP_P    = PW'(EXTRA_DEPTH);
    localparam logic [HW-1:0]       HEAD_MAX = HW'(EXTRA_DEPTH - 1);
    localparam logic [EAW-1:0]      DEP_E    = EAW'(EXTRA_DEPTH);

    logic          present_reg [WINDOW_SLOTS];
    logic          done_reg    [WINDOW_SLOTS];
    logic [CW-1:0] count_reg   [WINDOW_SLOTS];
    logic [HW-1:0] head_reg    [WINDOW_SLOTS];
    logic [SEQ_BITS-1:0] cur_seq_reg;
    logic [SW-1:0]       cur_slot_reg;

    logic [SEQ_BITS-1:0] diff;
    logic                in_win;
    logic [SW:0]         reg_sum;
    logic [SW-1:0]       reg_slot;
    logic [SW-1:0]       slot;
    logic                pres;
    logic                done;
    logic [CW-1:0]       count;
    logic [HW-1:0]       head;
    logic [PW-1:0]       pos_sum;
    logic [PW-1:0]       pos_mod;
    logic [HW-1:0]       pos;
    logic [HW-1:0]       head_inc;
    logic [CW-1:0]       cnt_after;
    logic [HW-1:0]       ext_idx;

    logic          present_next;
    logic          done_next;
    logic [CW-1:0] count_next;
    logic [HW-1:0] head_next;
    logic          slot_we;
    logic          cur_adv;

    assign diff     = packet_sequence - cur_seq_reg;
    assign in_win   = (packet_sequence >= cur_seq_reg) && (diff < WIN_S);
    // seq mod window, from the slot of the current sequence plus the offset
    assign reg_sum  = {1'b0, cur_slot_reg} + {1'b0, diff[SW-1:0]};
    assign reg_slot = (reg_sum >= WIN_W) ? SW'(reg_sum - WIN_W) : reg_sum[SW-1:0];
    assign slot     = (cmd == CMD_FETCH) ? cur_slot_reg : reg_slot;

    assign pres  = present_reg[slot];
    assign done  = done_reg[slot];
    assign count = count_reg[slot];
    assign head  = head_reg[slot];

    assign pos_sum  = PW'(head) + PW'(count);
    assign pos_mod  = (pos_sum >= DEP_P) ? (pos_sum - DEP_P) : pos_sum;
    assign pos      = pos_mod[HW-1:0];
    assign head_inc = (head == HEAD_MAX) ? '0 : head + HW'(1);

    always_comb begin
        flags        = '0;
        present_next = pres;
        done_next    = done;
        count_next   = count;
        head_next    = head;
        cnt_after    = count;
        ext_idx      = pos;
        slot_we      = 1'b0;
        cur_adv      = 1'b0;
        unique case (cmd)
            CMD_REG_RELIABLE: begin
                if (in_win && !pres) begin
                    present_next   = 1'b1;
                    done_next      = 1'b0;
                    slot_we        = 1'b1;
                    flags.accepted = 1'b1;
                    flags.rel_wr   = 1'b1;
                end
            end
            CMD_REG_BEST: begin
                if (in_win && (count != CNT_FULL)) begin
                    count_next     = count + CW'(1);
                    slot_we        = 1'b1;
                    flags.accepted = 1'b1;
                    flags.ext_wr   = 1'b1;
                end
            end
            CMD_FETCH: begin
                if (pres) begin
                    slot_we = 1'b1;
                    if (!done) begin
                        done_next       = 1'b1;
                        flags.delivered = 1'b1;
                        flags.rel_rd    = 1'b1;
                    end else if (count != '0) begin
                        flags.delivered = 1'b1;
                        flags.kind      = 1'b1;
                        flags.ext_rd    = 1'b1;
                        ext_idx         = head;
                        head_next       = head_inc;
                        cnt_after       = count - CW'(1);
                    end
                    count_next = cnt_after;
                    // slot drained: free it and move on
                    if (cnt_after == '0) begin
                        present_next = 1'b0;
                        done_next    = 1'b0;
                        head_next    = '0;
                        cur_adv      = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW_SLOTS; i++) begin
                present_reg[i] <= 1'b0;
                done_reg[i]    <= 1'b0;
                count_reg[i]   <= '0;
                head_reg[i]    <= '0;
            end
            cur_seq_reg  <= '0;
            cur_slot_reg <= '0;
        end else if (step) begin
            if (slot_we) begin
                present_reg[slot] <= present_next;
                done_reg[slot]    <= done_next;
                count_reg[slot]   <= count_next;
                head_reg[slot]    <= head_next;
            end
            if (cur_adv) begin
                cur_seq_reg <= cur_seq_reg + SEQ_BITS'(1);
                if (cur_seq_reg == SEQ_MAX || cur_slot_reg == SLOT_MAX) begin
                    cur_slot_reg <= '0;
                end else begin
                    cur_slot_reg <= cur_slot_reg + SW'(1);
                end
            end
        end
    end

    assign cur_sequence = cur_seq_reg;
    assign rel_addr     = slot;
    assign ext_addr     = EAW'(slot) * DEP_E + EAW'(ext_idx);

endmodule

// ===== rtl/core/sequenced_packet_reorder_buffer_top.sv =====
// Top level of the sequenced packet reorder buffer.
//
// Input channel (s_*): one command word per handshake: register a reliable
// packet, register a best-effort packet, or fetch the next packet in order.
// Output channel (m_*): exactly one result word per command, in command order.
// A word is accepted on a rising edge with valid and ready both high.
// Path: an accepted command passes the input register, then the slot decision
// with descriptor RAM read, then the output register, whose contents show on m_*.
// Throughput: one word per cycle while the receiver does not stall; each command
// does a single read-modify-write of one slot's state, and the descriptor
// RAMs take one access per cycle.
// Reset (aresetn low, synchronous): all slots empty, current sequence zero,
// no result pending; usable in the first cycle after reset, no clearing pass.
// Descriptor RAMs are not cleared; only written entries are ever read.
// Receiver stall: the result is held on m_* while m_ready is low; the two
// internal stages keep filling, then s_ready drops until m_ready returns.
module sequenced_packet_reorder_buffer_top import srb_pkg::*; #(
    parameter int WINDOW_SLOTS = WINDOW_SLOTS_DEFAULT,
    parameter int EXTRA_DEPTH  = EXTRA_DEPTH_DEFAULT,
    parameter int HANDLE_BITS  = HANDLE_BITS_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [1:0]             s_cmd,
    input  logic [SEQ_BITS-1:0]    s_packet_sequence,
    input  logic [HANDLE_BITS-1:0] s_packet_descriptor,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_accepted,
    output logic                   m_delivered,
    output logic [SEQ_BITS-1:0]    m_out_sequence,
    output logic [HANDLE_BITS-1:0] m_out_descriptor,
    output logic                   m_out_kind
);

    localparam int SW  = $clog2(WINDOW_SLOTS);
    localparam int EAW = $clog2(WINDOW_SLOTS * EXTRA_DEPTH);

    logic                   a_valid_reg;
    logic [1:0]             a_cmd_reg;
    logic [SEQ_BITS-1:0]    a_seq_reg;
    logic [HANDLE_BITS-1:0] a_desc_reg;

    logic                   b_valid_reg;
    srb_flags_t             b_flags_reg;
    logic [SEQ_BITS-1:0]    b_seq_reg;

    logic                   m_valid_reg;
    logic                   m_accepted_reg;
    logic                   m_delivered_reg;
    logic [SEQ_BITS-1:0]    m_seq_reg;
    logic [HANDLE_BITS-1:0] m_desc_reg;
    logic                   m_kind_reg;

    logic                   a_adv;
    logic                   b_adv;
    srb_flags_t             flags;
    logic [SEQ_BITS-1:0]    cur_sequence;
    logic [SW-1:0]          rel_addr;
    logic [EAW-1:0]         ext_addr;
    logic [HANDLE_BITS-1:0] rel_rdata;
    logic [HANDLE_BITS-1:0] ext_rdata;

    assign b_adv   = b_valid_reg && (!m_valid_reg || m_ready);
    assign a_adv   = a_valid_reg && (!b_valid_reg || b_adv);
    assign s_ready = !a_valid_reg || a_adv;

    srb_slot_ctrl #(
        .WINDOW_SLOTS (WINDOW_SLOTS),
        .EXTRA_DEPTH  (EXTRA_DEPTH)
    ) u_slot_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .step            (a_adv),
        .cmd             (a_cmd_reg),
        .packet_sequence (a_seq_reg),
        .flags           (flags),
        .cur_sequence    (cur_sequence),
        .rel_addr        (rel_addr),
        .ext_addr        (ext_addr)
    );

    srb_ram #(
        .WIDTH (HANDLE_BITS),
        .DEPTH (WINDOW_SLOTS)
    ) u_rel_ram (
        .aclk    (aclk),
        .wr_en   (a_adv && flags.rel_wr),
        .wr_addr (rel_addr),
        .wr_data (a_desc_reg),
        .rd_en   (a_adv && flags.rel_rd),
        .rd_addr (rel_addr),
        .rd_data (rel_rdata)
    );

    srb_ram #(
        .WIDTH (HANDLE_BITS),
        .DEPTH (WINDOW_SLOTS * EXTRA_DEPTH)
    ) u_ext_ram (
        .aclk    (aclk),
        .wr_en   (a_adv && flags.ext_wr),
        .wr_addr (ext_addr),
        .wr_data (a_desc_reg),
        .rd_en   (a_adv && flags.ext_rd),
        .rd_addr (ext_addr),
        .rd_data (ext_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                a_valid_reg <= s_valid;
            end
            if (!b_valid_reg || b_adv) begin
                b_valid_reg <= a_adv;
            end
            if (!m_valid_reg || m_ready) begin
                m_valid_reg <= b_adv;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            a_cmd_reg  <= s_cmd;
            a_seq_reg  <= s_packet_sequence;
            a_desc_reg <= s_packet_descriptor;
        end
        if (a_adv) begin
            b_flags_reg <= flags;
            b_seq_reg   <= flags.delivered ? cur_sequence : '0;
        end
        if (b_adv) begin
            m_accepted_reg  <= b_flags_reg.accepted;
            m_delivered_reg <= b_flags_reg.delivered;
            m_seq_reg       <= b_seq_reg;
            m_kind_reg      <= b_flags_reg.kind;
            if (!b_flags_reg.delivered) begin
                m_desc_reg <= '0;
            end else if (b_flags_reg.kind) begin
                m_desc_reg <= ext_rdata;
            end else begin
                m_desc_reg <= rel_rdata;
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_accepted       = m_accepted_reg;
    assign m_delivered      = m_delivered_reg;
    assign m_out_sequence   = m_seq_reg;
    assign m_out_descriptor = m_desc_reg;
    assign m_out_kind       = m_kind_reg;

`ifndef SYNTH
    a_no_accept_and_deliver: assert property (@(posedge aclk) disable iff (!aresetn)
        a_adv |-> !(flags.accepted && flags.delivered))
        else $error("command both stored and delivered a word");

    a_one_ram_access: assert property (@(posedge aclk) disable iff (!aresetn)
        a_adv |-> $countones({flags.rel_wr, flags.rel_rd, flags.ext_wr, flags.ext_rd}) <= 1)
        else $error("more than one descriptor access for one command");

    a_stage_held_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (b_valid_reg && m_valid_reg && !m_ready) |=> (b_valid_reg && $stable(b_flags_reg)))
        else $error("pending word lost while output stalled");

    a_advance_on_fetch: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && !$stable(cur_sequence)) |-> $past(a_adv && flags.delivered))
        else $error("current sequence moved without a delivering fetch");
`endif

endmodule

// ===== bench/srb_checker.sv =====
// Checker: predicts every result word of the reorder buffer and compares it with the m_ channel.
`timescale 1ns / 1ps

module srb_checker import srb_pkg::*; #(
    parameter int WINDOW_SLOTS = WINDOW_SLOTS_DEFAULT,
    parameter int EXTRA_DEPTH  = EXTRA_DEPTH_DEFAULT,
    parameter int HANDLE_BITS  = HANDLE_BITS_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  logic [1:0]             s_cmd,
    input  logic [SEQ_BITS-1:0]    s_packet_sequence,
    input  logic [HANDLE_BITS-1:0] s_packet_descriptor,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  logic                   m_accepted,
    input  logic                   m_delivered,
    input  logic [SEQ_BITS-1:0]    m_out_sequence,
    input  logic [HANDLE_BITS-1:0] m_out_descriptor,
    input  logic                   m_out_kind,
    output int                     fail_count,
    output int                     pending,
    output int                     delivered_count,
    output logic [SEQ_BITS-1:0]    head_sequence
);

    typedef struct packed {
        logic                   accepted;
        logic                   delivered;
        logic [SEQ_BITS-1:0]    seq;
        logic [HANDLE_BITS-1:0] desc;
        logic                   kind;
    } outcome_t;

    logic [SEQ_BITS-1:0]    cur_seq;
    logic                   rel_present [WINDOW_SLOTS];
    logic                   rel_done    [WINDOW_SLOTS];
    logic [HANDLE_BITS-1:0] rel_handle  [WINDOW_SLOTS];
    int                     be_count    [WINDOW_SLOTS];
    int                     be_head     [WINDOW_SLOTS];
    logic [HANDLE_BITS-1:0] be_handle   [WINDOW_SLOTS][EXTRA_DEPTH];

    outcome_t expected_words[$];
    int       errors = 0;
    int       n_delivered = 0;

    task automatic clear_slots();
        cur_seq = '0;
        for (int i = 0; i < WINDOW_SLOTS; i++) begin
            rel_present[i] = 1'b0;
            rel_done[i]    = 1'b0;
            be_count[i]    = 0;
            be_head[i]     = 0;
        end
        expected_words.delete();
    endtask

    function automatic outcome_t reorder_step(input logic [1:0] cmd,
                                              input logic [SEQ_BITS-1:0] seq,
                                              input logic [HANDLE_BITS-1:0] desc);
        outcome_t res;
        int       slot;
        int       pos;
        res = '0;
        case (cmd)
            CMD_REG_RELIABLE, CMD_REG_BEST: begin
                if (seq >= cur_seq && (seq - cur_seq) < WINDOW_SLOTS) begin
                    slot = int'(seq % WINDOW_SLOTS);
                    if (cmd == CMD_REG_RELIABLE) begin
                        if (!rel_present[slot]) begin
                            rel_present[slot] = 1'b1;
                            rel_done[slot]    = 1'b0;
                            rel_handle[slot]  = desc;
                            res.accepted      = 1'b1;
                        end
                    end else if (be_count[slot] < EXTRA_DEPTH) begin
                        pos = (be_head[slot] + be_count[slot]) % EXTRA_DEPTH;
                        be_handle[slot][pos] = desc;
                        be_count[slot]++;
                        res.accepted = 1'b1;
                    end
                end
            end
            CMD_FETCH: begin
                slot = int'(cur_seq % WINDOW_SLOTS);
                if (rel_present[slot]) begin
                    if (!rel_done[slot]) begin
                        rel_done[slot] = 1'b1;
                        res.delivered  = 1'b1;
                        res.seq        = cur_seq;
                        res.desc       = rel_handle[slot];
                        res.kind       = 1'b0;
                    end else if (be_count[slot] > 0) begin
                        res.delivered = 1'b1;
                        res.seq       = cur_seq;
                        res.desc      = be_handle[slot][be_head[slot]];
                        res.kind      = 1'b1;
                        be_head[slot] = (be_head[slot] + 1) % EXTRA_DEPTH;
                        be_count[slot]--;
                    end
                    if (be_count[slot] == 0) begin
                        rel_present[slot] = 1'b0;
                        rel_done[slot]    = 1'b0;
                        be_head[slot]     = 0;
                        cur_seq           = cur_seq + 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    always @(posedge aclk) begin : watch_channels
        outcome_t got;
        outcome_t want;
        logic     bad;
        if (!aresetn) begin
            clear_slots();
        end else begin
            if (s_valid && s_ready) begin
                expected_words.push_back(reorder_step(s_cmd, s_packet_sequence,
                                                      s_packet_descriptor));
            end
            if (m_valid && m_ready) begin
                got.accepted  = m_accepted;
                got.delivered = m_delivered;
                got.seq       = m_out_sequence;
                got.desc      = m_out_descriptor;
                got.kind      = m_out_kind;
                if (expected_words.size() == 0) begin
                    $display("%0t: result word with nothing expected: %h", $time, got);
                    errors++;
                end else begin
                    want = expected_words[0];
                    expected_words.delete(0);
                    bad  = 1'b0;
                    if (got.accepted !== want.accepted) begin
                        $display("%0t: accepted exp %b act %b", $time, want.accepted,
                                 got.accepted);
                        bad = 1'b1;
                    end
                    if (got.delivered !== want.delivered) begin
                        $display("%0t: delivered exp %b act %b", $time, want.delivered,
                                 got.delivered);
                        bad = 1'b1;
                    end
                    if (got.seq !== want.seq) begin
                        $display("%0t: out_sequence exp %h act %h", $time, want.seq, got.seq);
                        bad = 1'b1;
                    end
                    if (got.desc !== want.desc) begin
                        $display("%0t: out_descriptor exp %h act %h", $time, want.desc,
                                 got.desc);
                        bad = 1'b1;
                    end
                    if (got.kind !== want.kind) begin
                        $display("%0t: out_kind exp %b act %b", $time, want.kind, got.kind);
                        bad = 1'b1;
                    end
                    if (bad) errors++;
                    if (want.delivered) n_delivered++;
                end
            end
        end
        fail_count      <= errors;
        pending         <= expected_words.size();
        delivered_count <= n_delivered;
        head_sequence   <= cur_seq;
    end

endmodule

// ===== bench/tb.sv =====
// Testbench top: drives command words into the reorder buffer and reports the verdict.
`timescale 1ns / 1ps

module tb import srb_pkg::*; ();

    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         WIN            = WINDOW_SLOTS_DEFAULT;
    localparam logic [1:0] CMD_UNUSED     = 2'd3;

    logic                  aclk                = 1'b0;
    logic                  aresetn             = 1'b0;
    logic                  s_valid             = 1'b0;
    logic [1:0]            s_cmd               = '0;
    logic [SEQ_BITS-1:0]   s_packet_sequence   = '0;
    logic [31:0]           s_packet_descriptor = '0;
    logic                  m_ready             = 1'b0;
    logic                  s_ready;
    logic                  m_valid;
    logic                  m_accepted;
    logic                  m_delivered;
    logic [SEQ_BITS-1:0]   m_out_sequence;
    logic [31:0]           m_out_descriptor;
    logic                  m_out_kind;

    int                    fail_count;
    int                    pending;
    int                    delivered_count;
    logic [SEQ_BITS-1:0]   head_sequence;

    bit                    rx_idle     = 1'b1;
    int                    stall_left  = 0;
    int                    idle_cycles = 0;
    int                    words_sent  = 0;

    sequenced_packet_reorder_buffer_top u_top (.*);

    srb_checker u_checker (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (rx_idle && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 11);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    task automatic send_word(input logic [1:0] cmd, input logic [SEQ_BITS-1:0] seq,
                             input logic [31:0] desc);
        s_valid             <= 1'b1;
        s_cmd               <= cmd;
        s_packet_sequence   <= seq;
        s_packet_descriptor <= desc;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
    endtask

    // mostly in-window traffic near the head, with some noise
    task automatic send_random_word();
        int                  pick;
        int                  offset;
        logic [1:0]          cmd;
        logic [SEQ_BITS-1:0] seq;
        logic [31:0]         desc;
        pick   = $urandom_range(0, 99);
        desc   = $urandom();
        seq    = SEQ_BITS'($urandom());
        offset = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) : $urandom_range(0, WIN - 1);
        if (pick < 35) begin
            cmd = CMD_FETCH;
        end else if (pick < 65) begin
            cmd = CMD_REG_RELIABLE;
            seq = SEQ_BITS'(head_sequence + offset);
        end else if (pick < 90) begin
            cmd = CMD_REG_BEST;
            seq = SEQ_BITS'(head_sequence + offset);
        end else begin
            cmd = ($urandom_range(0, 1) == 0) ? CMD_REG_RELIABLE : CMD_REG_BEST;
            case ($urandom_range(0, 3))
                0: cmd = CMD_UNUSED;
                1: seq = head_sequence - 1'b1;
                2: seq = SEQ_BITS'(head_sequence + WIN + $urandom_range(0, 4));
                default: begin
                end
            endcase
        end
        send_word(cmd, seq, desc);
    endtask

    task automatic run_phase(input int count, input bit sender_gaps, input bit receiver_stalls);
        rx_idle <= receiver_stalls;
        repeat (count) begin
            if (sender_gaps && $urandom_range(0, 3) == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
            send_random_word();
        end
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty fetch, unused command, window edges, duplicates, full queue
        send_word(CMD_FETCH,        31'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_word(CMD_UNUSED,       31'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_word(CMD_REG_BEST,     31'd0,         32'h0000_0000);
        send_word(CMD_FETCH,        31'd0,         32'h0000_0000);
        send_word(CMD_REG_RELIABLE, 31'd0,         32'hFFFF_FFFF);
        send_word(CMD_REG_RELIABLE, 31'd0,         32'h0000_0001);
        send_word(CMD_REG_BEST,     31'd0,         32'hA5A5_A5A5);
        send_word(CMD_REG_BEST,     31'd0,         32'h5A5A_5A5A);
        send_word(CMD_REG_BEST,     31'd0,         32'h8000_0000);
        send_word(CMD_REG_BEST,     31'd0,         32'h1234_5678);
        send_word(CMD_REG_RELIABLE, 31'd15,        32'h0F0F_0F0F);
        send_word(CMD_REG_RELIABLE, 31'd16,        32'hF0F0_F0F0);
        send_word(CMD_REG_RELIABLE, 31'h7FFF_FFFF, 32'hDEAD_BEEF);
        send_word(CMD_FETCH,        31'd0,         32'h0000_0000);
        send_word(CMD_REG_RELIABLE, 31'd0,         32'hCAFE_0000);
        repeat (4) send_word(CMD_FETCH, 31'h5555_5555, 32'hAAAA_AAAA);
        send_word(CMD_REG_BEST,     31'd0,         32'h0000_0002);
        send_word(CMD_REG_RELIABLE, 31'd1,         32'h7FFF_FFFF);
        send_word(CMD_FETCH,        31'd0,         32'h0000_0000);
        send_word(CMD_FETCH,        31'd0,         32'h0000_0000);

        run_phase(400, 1'b1, 1'b1);
        wait_for_results();
        run_phase(300, 1'b0, 1'b1);
        run_phase(400, 1'b1, 1'b1);
        run_phase(200, 1'b0, 1'b0);
        wait_for_results();
        repeat (8) @(posedge aclk);

        $display("Sent %0d command words; %0d packets came out in sequence order.",
                 words_sent, delivered_count);
        $display("Hit window edges, duplicate and full-queue rejects, empty fetches, both stalls.");
        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
